[rtl/rlse_pkg.sv]
// Shared types, constants and the nibble encoder for the RGB LED SPI encoder.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps

package rlse_pkg;

  // One LED after scaling, as held in the queue between front and back
  typedef struct packed {
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
    logic       frame_end;
  } led_entry_t;

  localparam int          QueueDepth  = 2;
  localparam int          QueuePtrW   = 1;
  localparam int          QueueCountW = 2;
  localparam int          WordIdxW    = 3;
  localparam logic [2:0]  LastWordIdx = 3'd5;
  localparam logic [12:0] BasePattern = 13'b0100100100100;
  localparam logic [16:0] RoundHalf   = 17'd128;

  // Channel select codes, taken from the upper bits of the word index
  localparam logic [1:0]  ChanGreen   = 2'd0;
  localparam logic [1:0]  ChanRed     = 2'd1;
  localparam logic [1:0]  ChanBlue    = 2'd2;

  // Four data bits to 13 SPI bits: each bit becomes 110 or 100, MSB first
  function automatic logic [12:0] nibble_word(input logic [3:0] nib);
    logic [12:0] w;
    w     = BasePattern;
    w[10] = nib[3];
    w[7]  = nib[2];
    w[4]  = nib[1];
    w[1]  = nib[0];
    return w;
  endfunction

endpackage

[rtl/rlse_front.sv]
// Front end: blanks an off LED and scales each channel by the brightness.
// Depends on rlse_pkg for the queue entry type and the rounding constant.
`timescale 1ns / 1ps

module rlse_front (
  input  logic                  led_on,
  input  logic [23:0]           colour,
  input  logic [7:0]            level,
  input  logic                  frame_end,
  output rlse_pkg::led_entry_t  entry
);

  logic [8:0]  gain;
  logic [7:0]  g_in, r_in, b_in;
  logic [16:0] g_prod, r_prod, b_prod;

  // Off LED sends black on all channels
  assign g_in = led_on ? colour[15:8]  : 8'd0;
  assign r_in = led_on ? colour[23:16] : 8'd0;
  assign b_in = led_on ? colour[7:0]   : 8'd0;
  assign gain = {1'b0, level} + 9'd1;

  // byte * (level + 1) + 128, then divide by 256; result never exceeds 255
  assign g_prod = {1'b0, 8'(0) + g_in * 16'(gain)} + rlse_pkg::RoundHalf;
  assign r_prod = {1'b0, 8'(0) + r_in * 16'(gain)} + rlse_pkg::RoundHalf;
  assign b_prod = {1'b0, 8'(0) + b_in * 16'(gain)} + rlse_pkg::RoundHalf;

  always_comb begin
    entry.green     = g_prod[15:8];
    entry.red       = r_prod[15:8];
    entry.blue      = b_prod[15:8];
    entry.frame_end = frame_end;
  end

endmodule

[rtl/rlse_queue.sv]
// Two-entry queue between the front end and the word sequencer.
// Depends on rlse_pkg for the entry type and queue sizing.
`timescale 1ns / 1ps

module rlse_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rlse_pkg::led_entry_t  push_entry,
  input  logic                  pop,
  output logic                  full,
  output logic                  not_empty,
  output rlse_pkg::led_entry_t  head
);

  rlse_pkg::led_entry_t                 store [rlse_pkg::QueueDepth];
  logic [rlse_pkg::QueuePtrW-1:0]       wr_ptr;
  logic [rlse_pkg::QueuePtrW-1:0]       rd_ptr;
  logic [rlse_pkg::QueueCountW-1:0]     count;

  assign full      = (count == rlse_pkg::QueueCountW'(rlse_pkg::QueueDepth));
  assign not_empty = (count != '0);
  assign head      = store[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) store[wr_ptr] <= push_entry;
  end

endmodule

[rtl/rlse_back.sv]
// Back end: walks the six nibbles of the head LED and drives the output register.
// Depends on rlse_pkg for the entry type, word index constants and nibble_word.
`timescale 1ns / 1ps

module rlse_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  rlse_pkg::led_entry_t  q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [12:0]           spi_word,
  output logic                  led_last,
  output logic                  frame_last
);

  logic [rlse_pkg::WordIdxW-1:0] word_idx;
  logic                          load;
  logic                          emit;
  logic                          is_last;
  logic [7:0]                    chan;
  logic [3:0]                    nib;

  assign load    = !out_valid || out_ready;
  assign emit    = load && q_valid;
  assign is_last = (word_idx == rlse_pkg::LastWordIdx);
  assign q_pop   = emit && is_last;

  // Channel in send order, then high or low half
  always_comb begin
    case (word_idx[2:1])
      rlse_pkg::ChanGreen: chan = q_head.green;
      rlse_pkg::ChanRed:   chan = q_head.red;
      rlse_pkg::ChanBlue:  chan = q_head.blue;
      default:             chan = q_head.blue;
    endcase
    nib = word_idx[0] ? chan[3:0] : chan[7:4];
  end

  // Word counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      word_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) out_valid <= q_valid;
      if (emit) word_idx <= is_last ? '0 : word_idx + 1'b1;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      spi_word   <= rlse_pkg::nibble_word(nib);
      led_last   <= is_last;
      frame_last <= is_last && q_head.frame_end;
    end
  end

endmodule

[rtl/rgb_led_spi_bit_encoder_core.sv]
// Top level of the RGB LED SPI bit encoder: front end, queue and word sequencer.
// Depends on rlse_pkg, rlse_front, rlse_queue and rlse_back.
`timescale 1ns / 1ps

// Takes one LED per input word (on flag, 24-bit RGB colour, 8-bit brightness,
// frame end flag) and gives six 13-bit SPI words for it, green, red, blue, high
// nibble first, each data bit coded as 110 or 100. led_last marks the sixth word
// of an LED and frame_last that word when frame_end was set. The output side
// emits one word per cycle unless out_ready stalls it or the queue is empty;
// the word sequencer sets that rate. Scaling is done at acceptance and two
// LEDs can wait in the queue, so input and output stall independently. An
// accepted LED is queued first; the output register then loads from the queue.
module rgb_led_spi_bit_encoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        led_on,
  input  logic [23:0] colour,
  input  logic [7:0]  level,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [12:0] spi_word,
  output logic        led_last,
  output logic        frame_last
);

  rlse_pkg::led_entry_t front_entry;
  rlse_pkg::led_entry_t head_entry;
  logic                 q_full;
  logic                 q_valid;
  logic                 q_pop;
  logic                 push;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  rlse_front u_front (
    .led_on    (led_on),
    .colour    (colour),
    .level     (level),
    .frame_end (frame_end),
    .entry     (front_entry)
  );

  rlse_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (front_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_valid),
    .head       (head_entry)
  );

  rlse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_head     (head_entry),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .spi_word   (spi_word),
    .led_last   (led_last),
    .frame_last (frame_last)
  );

endmodule
